// ===== rtl/rbsi_pkg.sv =====
// Shared types, constants and helpers for the ray/box slab intersection block.
// No dependencies; imported by every module of the block.
package rbsi_pkg;

  localparam int unsigned DataW     = 32;                 // Q16.16 word
  localparam int unsigned FracW     = 16;                 // fraction bits
  localparam int unsigned TolW      = 16;                 // tolerance register
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumStages = 5;
  localparam int unsigned DiffW     = DataW + 1;          // corner - origin, exact
  localparam int unsigned ProdW     = DiffW + DataW;      // full product, Q33.32
  localparam int unsigned ShW       = ProdW - FracW;      // product after rescale
  localparam int unsigned InTdataW  = 12 * DataW;         // 384
  localparam int unsigned OutUsedW  = 1 + 3 * DataW;      // 97
  localparam int unsigned OutTdataW = ((OutUsedW + 7) / 8) * 8;  // 104
  localparam int unsigned OutPadW   = OutTdataW - OutUsedW;

  localparam logic [TolW-1:0]  TolReset = 16'd7;
  localparam logic [DataW-1:0] QMax     = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] QMin     = 32'h8000_0000;

  typedef logic signed [DataW-1:0] q16_t;

  // Load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // One result word before packing
  typedef struct packed {
    logic hit;
    q16_t hit_time;
    q16_t t_near;
    q16_t t_far;
  } result_t;

  // Floor rescale of a Q33.32 product to Q16.16 with saturation
  function automatic q16_t sat_rescale(input logic signed [ProdW-1:0] p);
    logic [ShW-1:0] sh;
    logic           fits;
    q16_t           r;
    sh   = p[ProdW-1:FracW];
    fits = (&sh[ShW-1:DataW-1]) || !(|sh[ShW-1:DataW-1]);
    if (fits) begin
      r = sh[DataW-1:0];
    end else if (sh[ShW-1]) begin
      r = QMin;
    end else begin
      r = QMax;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rbsi_slab.sv =====
// One axis of the slab test: differences, products, rescale and min/max.
// Three register stages; depends on rbsi_pkg.
module rbsi_slab (
  input  logic                clk_i,
  input  rbsi_pkg::stage_en_t en_i,
  input  rbsi_pkg::q16_t      origin_i,
  input  rbsi_pkg::q16_t      inv_dir_i,
  input  rbsi_pkg::q16_t      box_min_i,
  input  rbsi_pkg::q16_t      box_max_i,
  output rbsi_pkg::q16_t      slab_min_o,
  output rbsi_pkg::q16_t      slab_max_o
);
  import rbsi_pkg::*;

  logic signed [DiffW-1:0] dlo_d, dlo_q, dhi_d, dhi_q;
  q16_t                    inv_q;
  logic signed [ProdW-1:0] plo_d, plo_q, phi_d, phi_q;
  q16_t                    lo, hi;
  q16_t                    mn_q, mx_q;

  // Stage 1: corner minus origin, exact at 33 bits
  always_comb begin
    dlo_d = $signed({box_min_i[DataW-1], box_min_i}) - $signed({origin_i[DataW-1], origin_i});
    dhi_d = $signed({box_max_i[DataW-1], box_max_i}) - $signed({origin_i[DataW-1], origin_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dlo_q <= dlo_d;
      dhi_q <= dhi_d;
      inv_q <= inv_dir_i;
    end
  end

  // Stage 2: signed 33x32 products
  always_comb begin
    plo_d = dlo_q * inv_q;
    phi_d = dhi_q * inv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // Stage 3: rescale, saturate and order the two slab distances
  always_comb begin
    lo = sat_rescale(plo_q);
    hi = sat_rescale(phi_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mn_q <= (lo < hi) ? lo : hi;
      mx_q <= (lo < hi) ? hi : lo;
    end
  end

  assign slab_min_o = mn_q;
  assign slab_max_o = mx_q;

endmodule

// ===== rtl/rbsi_reduce.sv =====
// Combines the per-axis slabs into entry/exit distances and the hit decision.
// Two register stages, the second being the output register; depends on rbsi_pkg.
module rbsi_reduce (
  input  logic                      clk_i,
  input  rbsi_pkg::stage_en_t       en_i,
  input  rbsi_pkg::q16_t [2:0]      slab_min_i,
  input  rbsi_pkg::q16_t [2:0]      slab_max_i,
  input  logic [rbsi_pkg::TolW-1:0] tol_i,
  output rbsi_pkg::result_t         res_o
);
  import rbsi_pkg::*;

  q16_t              near_d, near_q, far_d, far_q;
  logic signed [33:0] near_w, sum_w;
  logic              hit;
  result_t           res_d, res_q;

  // Stage 4: largest minimum and smallest maximum
  always_comb begin
    near_d = $signed(slab_min_i[0]);
    far_d  = $signed(slab_max_i[0]);
    for (int a = 1; a < NumAxes; a++) begin
      if ($signed(slab_min_i[a]) > near_d) near_d = $signed(slab_min_i[a]);
      if ($signed(slab_max_i[a]) < far_d)  far_d  = $signed(slab_max_i[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      near_q <= near_d;
      far_q  <= far_d;
    end
  end

  // Stage 5: tolerance compares at full precision
  // miss when near > far + tol, or when far + tol < 0
  always_comb begin
    near_w = $signed({{2{near_q[DataW-1]}}, near_q});
    sum_w  = $signed({{2{far_q[DataW-1]}}, far_q}) + $signed({18'd0, tol_i});
    hit    = !(near_w > sum_w) && !sum_w[33];
    res_d.hit      = hit;
    res_d.hit_time = hit ? near_q : QMax;
    res_d.t_near   = near_q;
    res_d.t_far    = far_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/ray_box_slab_intersection.sv =====
// Ray / axis-aligned box slab intersection, fully pipelined; while the output is
// not stalled (m_axis_tready high) it runs one test per cycle, and a new word is
// accepted every cycle. The five stages are: corner-minus-origin, 33x32
// products, rescale/saturate with per-axis min/max, three-way max/min, and the
// tolerance compare into the output register. Each stage holds its word while
// the next one is full and stalled, so a stall backs up through s_axis_tready
// and bubbles are squeezed out. The tolerance register may only be written
// while no word is in flight. Depends on rbsi_pkg, rbsi_slab and rbsi_reduce.
module ray_box_slab_intersection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32b each)
  input  logic [rbsi_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // hit (1b), hit_time, t_near, t_far (32b each), zero pad to 104b
  output logic [rbsi_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [rbsi_pkg::TolW-1:0]      cfg_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o
);
  import rbsi_pkg::*;

  logic [TolW-1:0]      tol_q;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;
  stage_en_t            en;
  q16_t [2:0]           slab_min, slab_max;
  result_t              res;

  // Tolerance register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // A stage may load when it is empty or its word moves on
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];
  assign en.s5 = rdy[4];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = rdy[0];

  // Per-axis slab units
  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    rbsi_slab u_slab (
      .clk_i      (clk_i),
      .en_i       (en),
      .origin_i   (s_axis_tdata[a*DataW +: DataW]),
      .inv_dir_i  (s_axis_tdata[(3+a)*DataW +: DataW]),
      .box_min_i  (s_axis_tdata[(6+a)*DataW +: DataW]),
      .box_max_i  (s_axis_tdata[(9+a)*DataW +: DataW]),
      .slab_min_o (slab_min[a]),
      .slab_max_o (slab_max[a])
    );
  end

  rbsi_reduce u_reduce (
    .clk_i      (clk_i),
    .en_i       (en),
    .slab_min_i (slab_min),
    .slab_max_i (slab_max),
    .tol_i      (tol_q),
    .res_o      (res)
  );

  // Output word
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {{OutPadW{1'b0}}, res.t_far, res.t_near, res.hit_time, res.hit};

endmodule

// ===== rtl/rbsi_checker.sv =====
// Port-level checks for ray_box_slab_intersection, bound to the top level.
// Depends on rbsi_pkg.
module rbsi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rbsi_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import rbsi_pkg::*;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Empty output stage means the whole pipeline can take a word
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // A miss reports the largest Q16.16 value as hit time
  a_miss_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == QMax)
    else $error("miss without saturated hit time");

  // A hit reports the entry distance as hit time
  a_hit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[32:1] == m_axis_tdata[64:33])
    else $error("hit time differs from entry distance");

endmodule

bind ray_box_slab_intersection rbsi_checker u_rbsi_checker (.*);
